FILE: design/fqd_pkg.sv
// Shared types and constants for the FIFO queue with delete-by-value.
// Used by fqd_ctrl, fqd_datapath and fifo_queue_with_delete; no dependencies.
package fqd_pkg;

    localparam int DEPTH_DEF       = 16;
    localparam int VALUE_WIDTH_DEF = 32;

    localparam logic [1:0] CMD_ENQ = 2'd0;
    localparam logic [1:0] CMD_DEQ = 2'd1;
    localparam logic [1:0] CMD_DEL = 2'd2;
    localparam logic [1:0] CMD_NOP = 2'd3;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_NULL     = 3'd1;
    localparam logic [2:0] ST_EMPTY    = 3'd2;
    localparam logic [2:0] ST_FULL     = 3'd3;
    localparam logic [2:0] ST_NOTFOUND = 3'd4;

    typedef struct packed {
        logic [1:0]  command;
        logic [31:0] value;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] read_value;
        logic [4:0]  count;
    } t_out_item;

    typedef struct packed {
        logic       load_in;
        logic       do_enq;
        logic       do_deq;
        logic       scan_start;
        logic       scan_step;
        logic       out_load;
        logic [2:0] out_status;
    } t_dp_ctrl;

    typedef struct packed {
        logic [1:0] command;
        logic       val_null;
        logic       empty;
        logic       full;
        logic       found;
        logic       scan_last;
    } t_dp_stat;

endpackage

FILE: design/fqd_ctrl.sv
// Controller state machine for the FIFO queue with delete-by-value.
// Depends on fqd_pkg; drives fqd_datapath through t_dp_ctrl.
module fqd_ctrl
    import fqd_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    output logic     o_out_valid,
    input  logic     i_out_stall,
    input  t_dp_stat i_stat,
    output t_dp_ctrl o_ctrl
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_FINISH
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   out_free;

    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state = r_state;
        o_ctrl  = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_ctrl.load_in = 1'b1;
                    n_state        = S_EXEC;
                end
            end
            S_EXEC: begin
                if (out_free) begin
                    unique case (i_stat.command)
                        CMD_ENQ: begin
                            o_ctrl.out_load = 1'b1;
                            if (i_stat.val_null) begin
                                o_ctrl.out_status = ST_NULL;
                            end else if (i_stat.full) begin
                                o_ctrl.out_status = ST_FULL;
                            end else begin
                                o_ctrl.do_enq     = 1'b1;
                                o_ctrl.out_status = ST_OK;
                            end
                            n_state = S_IDLE;
                        end
                        CMD_DEQ: begin
                            o_ctrl.out_load = 1'b1;
                            if (i_stat.empty) begin
                                o_ctrl.out_status = ST_EMPTY;
                            end else begin
                                o_ctrl.do_deq     = 1'b1;
                                o_ctrl.out_status = ST_OK;
                            end
                            n_state = S_IDLE;
                        end
                        CMD_DEL: begin
                            if (i_stat.val_null) begin
                                o_ctrl.out_load   = 1'b1;
                                o_ctrl.out_status = ST_NULL;
                                n_state           = S_IDLE;
                            end else if (i_stat.empty) begin
                                o_ctrl.out_load   = 1'b1;
                                o_ctrl.out_status = ST_EMPTY;
                                n_state           = S_IDLE;
                            end else begin
                                o_ctrl.scan_start = 1'b1;
                                n_state           = S_SCAN;
                            end
                        end
                        CMD_NOP: begin
                            o_ctrl.out_load   = 1'b1;
                            o_ctrl.out_status = ST_OK;
                            n_state           = S_IDLE;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                o_ctrl.scan_step = 1'b1;
                if (i_stat.scan_last) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (out_free) begin
                    o_ctrl.out_load   = 1'b1;
                    o_ctrl.out_status = i_stat.found ? ST_OK : ST_NOTFOUND;
                    n_state           = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_ctrl.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // A pending result is never overwritten before it is taken.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctrl.out_load |-> out_free)
        else $error("result loaded over a pending transaction");

endmodule

FILE: design/fqd_datapath.sv
// Datapath for the FIFO queue with delete-by-value: shift-register cells,
// count, scan counter and output register. Depends on fqd_pkg.
module fqd_datapath
    import fqd_pkg::*;
#(
    parameter int DEPTH       = DEPTH_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_item  i_in_item,
    input  t_dp_ctrl  i_ctrl,
    output t_dp_stat  o_stat,
    output t_out_item o_out_item
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int EXT_W = (VALUE_WIDTH > 32) ? VALUE_WIDTH : 32;

    logic [VALUE_WIDTH-1:0] r_cells [DEPTH];
    logic [CNT_W-1:0]       r_count;
    logic [CNT_W-1:0]       n_count;
    logic [CNT_W-1:0]       r_steps;
    logic                   r_found;
    logic [1:0]             r_cmd;
    logic [VALUE_WIDTH-1:0] r_val;
    t_out_item              r_out;

    logic [EXT_W-1:0]       in_ext;
    logic [EXT_W-1:0]       head_ext;
    logic [VALUE_WIDTH-1:0] head;
    logic                   match;
    logic                   shift;
    logic                   write;
    logic [IDX_W-1:0]       wr_idx;
    logic [IDX_W-1:0]       tail_idx;
    logic [CNT_W-1:0]       count_m1;

    assign in_ext   = EXT_W'(i_in_item.value);
    assign head     = r_cells[0];
    assign head_ext = EXT_W'(head);
    assign match    = !r_found && (head == r_val);
    assign count_m1 = r_count - 1'b1;
    assign tail_idx = count_m1[IDX_W-1:0];

    assign shift  = i_ctrl.do_deq || i_ctrl.scan_step;
    assign write  = i_ctrl.do_enq || (i_ctrl.scan_step && !match);
    assign wr_idx = i_ctrl.do_enq ? r_count[IDX_W-1:0] : tail_idx;

    always_comb begin
        n_count = r_count;
        if (i_ctrl.do_enq) begin
            n_count = r_count + 1'b1;
        end else if (i_ctrl.do_deq || (i_ctrl.scan_step && match)) begin
            n_count = count_m1;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < DEPTH; i++) begin
            if (write && (wr_idx == IDX_W'(i))) begin
                r_cells[i] <= i_ctrl.do_enq ? r_val : head;
            end else if (shift && (i < DEPTH - 1)) begin
                r_cells[i] <= r_cells[(i < DEPTH - 1) ? i + 1 : i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_steps <= '0;
            r_found <= 1'b0;
        end else begin
            r_count <= n_count;
            if (i_ctrl.scan_start) begin
                r_steps <= r_count;
                r_found <= 1'b0;
            end else if (i_ctrl.scan_step) begin
                r_steps <= r_steps - 1'b1;
                if (match) begin
                    r_found <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load_in) begin
            r_cmd <= i_in_item.command;
            r_val <= in_ext[VALUE_WIDTH-1:0];
        end
        if (i_ctrl.out_load) begin
            r_out.status     <= i_ctrl.out_status;
            r_out.read_value <= i_ctrl.do_deq ? head_ext[31:0] : 32'd0;
            r_out.count      <= 5'(n_count);
        end
    end

    assign o_stat.command   = r_cmd;
    assign o_stat.val_null  = (r_val == '0);
    assign o_stat.empty     = (r_count == '0);
    assign o_stat.full      = (r_count == CNT_W'(DEPTH));
    assign o_stat.found     = r_found;
    assign o_stat.scan_last = (r_steps == CNT_W'(1));
    assign o_out_item       = r_out;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("entry count above depth");

    a_enq_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.do_enq |-> (r_count < CNT_W'(DEPTH)) && (r_val != '0))
        else $error("enqueue into a full queue or of a null handle");

    a_scan_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.scan_step |-> (r_steps != '0) && (r_count != '0))
        else $error("scan step with no entries left");

endmodule

FILE: design/fifo_queue_with_delete.sv
// Top level of the bounded FIFO queue with delete-by-value.
// Depends on fqd_pkg, fqd_ctrl and fqd_datapath.
//
//   Channel   Valid         Stall         Payload
//   input     i_in_valid    o_in_stall    i_in_item  (t_in_item)
//   output    o_out_valid   i_out_stall   o_out_item (t_out_item)
//
// Enqueue, dequeue, a rejected command and the unused command are taken in S_IDLE and answered from S_EXEC.
// Delete goes on from S_EXEC through S_SCAN and S_FINISH: it rotates the queue through cell 0, one entry
// a cycle, dropping the first matching handle.
// Reset clears the count; the cells hold stale data that is never read.
// A result waits in the output register; a new transaction is taken meanwhile.
module fifo_queue_with_delete
    import fqd_pkg::*;
#(
    parameter int DEPTH       = DEPTH_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    t_dp_ctrl dp_ctrl;
    t_dp_stat dp_stat;

    fqd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (dp_stat),
        .o_ctrl      (dp_ctrl)
    );

    fqd_datapath #(
        .DEPTH       (DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_item  (i_in_item),
        .i_ctrl     (dp_ctrl),
        .o_stat     (dp_stat),
        .o_out_item (o_out_item)
    );

endmodule

FILE: tb/fifo_queue_with_delete_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the FIFO queue with delete-by-value.
// Depends on fqd_pkg and fifo_queue_with_delete; it drives a directed table, then random
// command streams, and checks every result against the table's expected result or its own queue predictor.
module fifo_queue_with_delete_tb
    import fqd_pkg::*;
();

    localparam int RANDOM_COMMANDS = 1520;
    localparam int QUIET_COMMANDS  = 300;
    localparam int PAUSE_AT        = 700;
    localparam int HOLD_CYCLES     = 150;
    localparam int QUIET_CYCLES    = 400;
    localparam int DRAIN_CYCLES    = 40;
    localparam int CYCLE_LIMIT     = 400000;

    typedef struct packed {
        logic [1:0]  command;
        logic [31:0] value;
        logic [4:0]  reps;
        logic        typed;
        t_out_item   result;
    } t_step_row;

    logic      clk = 1'b0;
    logic      rst_n;
    logic      in_valid;
    logic      o_in_stall;
    t_in_item  in_item;
    logic      o_out_valid;
    logic      out_stall;
    t_out_item o_out_item;

    logic [31:0] held [DEPTH_DEF];
    int          held_count;
    t_out_item   expected_results [$];
    t_step_row   directed [$];
    int          status_seen [5];
    int          error_count;
    int          results_checked;
    int          commands_sent;
    int          cycle_count;
    logic        random_started;

    fifo_queue_with_delete u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (o_out_item)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results outstanding.",
                     cycle_count, expected_results.size());
            $display("Verification failed");
            $finish;
        end
    end

    function automatic void remove_entry(input int pos);
        for (int k = pos; k < held_count - 1; k++)
            held[k] = held[k + 1];
        held_count--;
    endfunction

    function automatic t_out_item apply_command(input t_in_item item);
        t_out_item res;
        int        hit;
        res = '0;
        res.status = ST_OK;
        hit = -1;
        case (item.command)
            CMD_ENQ: begin
                if (item.value == '0)
                    res.status = ST_NULL;
                else if (held_count == DEPTH_DEF)
                    res.status = ST_FULL;
                else begin
                    held[held_count] = item.value;
                    held_count++;
                end
            end
            CMD_DEQ: begin
                if (held_count == 0)
                    res.status = ST_EMPTY;
                else begin
                    res.read_value = held[0];
                    remove_entry(0);
                end
            end
            CMD_DEL: begin
                if (item.value == '0)
                    res.status = ST_NULL;
                else if (held_count == 0)
                    res.status = ST_EMPTY;
                else begin
                    for (int k = 0; k < held_count; k++)
                        if (hit < 0 && held[k] == item.value)
                            hit = k;
                    if (hit < 0)
                        res.status = ST_NOTFOUND;
                    else
                        remove_entry(hit);
                end
            end
            CMD_NOP: ;
        endcase
        res.count = 5'(held_count);
        status_seen[res.status]++;
        return res;
    endfunction

    function automatic t_in_item random_command(input bit filling);
        t_in_item item;
        int       roll;
        roll = $urandom_range(0, 99);
        item.value = $urandom();
        if (roll < 2) begin
            item.command = CMD_NOP;
        end else if (roll < (filling ? 72 : 27)) begin
            item.command = CMD_ENQ;
            if ($urandom_range(0, 1) == 1)
                item.value = $urandom_range(1, 24);
        end else if (roll < (filling ? 86 : 62)) begin
            item.command = CMD_DEQ;
        end else begin
            item.command = CMD_DEL;
            if (held_count > 0 && $urandom_range(0, 99) < 70)
                item.value = held[$urandom_range(0, held_count - 1)];
            else if ($urandom_range(0, 1) == 1)
                item.value = $urandom_range(1, 24);
        end
        if ($urandom_range(0, 99) < 3)
            item.value = '0;
        return item;
    endfunction

    function automatic t_step_row checked_row(input logic [1:0] command,
                                              input logic [31:0] value,
                                              input logic [2:0] status,
                                              input logic [31:0] read_value,
                                              input logic [4:0] count);
        t_step_row row;
        row.command           = command;
        row.value             = value;
        row.reps              = 5'd1;
        row.typed             = 1'b1;
        row.result.status     = status;
        row.result.read_value = read_value;
        row.result.count      = count;
        return row;
    endfunction

    function automatic t_step_row predicted_row(input logic [1:0] command,
                                                input logic [31:0] value,
                                                input logic [4:0] reps);
        t_step_row row;
        row         = '0;
        row.command = command;
        row.value   = value;
        row.reps    = reps;
        return row;
    endfunction

    // The transaction is taken at the rising edge that follows a falling edge
    // with the stall low; the queue state is predicted at that point.
    task automatic issue_command(input t_in_item item, input logic typed,
                                 input t_out_item typed_result);
        t_out_item predicted;
        in_valid <= 1'b1;
        in_item  <= item;
        do @(negedge clk); while (o_in_stall);
        predicted = apply_command(item);
        expected_results.push_back(typed ? typed_result : predicted);
        commands_sent++;
        @(posedge clk);
    endtask

    task automatic sender_gap(input bit allowed);
        if (allowed && $urandom_range(0, 99) < 20) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
    endtask

    initial begin : sender
        t_in_item item;
        rst_n          <= 1'b0;
        in_valid       <= 1'b0;
        in_item        <= '0;
        random_started <= 1'b0;
        held_count      = 0;

        directed.push_back(checked_row(CMD_DEQ, 32'hFFFF_FFFF, ST_EMPTY, 32'h0, 5'd0));
        directed.push_back(checked_row(CMD_DEL, 32'h0000_1234, ST_EMPTY, 32'h0, 5'd0));
        directed.push_back(checked_row(CMD_ENQ, 32'h0, ST_NULL, 32'h0, 5'd0));
        directed.push_back(checked_row(CMD_DEL, 32'h0, ST_NULL, 32'h0, 5'd0));
        directed.push_back(checked_row(CMD_NOP, 32'hFFFF_FFFF, ST_OK, 32'h0, 5'd0));
        directed.push_back(checked_row(CMD_ENQ, 32'hFFFF_FFFF, ST_OK, 32'h0, 5'd1));
        directed.push_back(checked_row(CMD_DEQ, 32'h0, ST_OK, 32'hFFFF_FFFF, 5'd0));
        directed.push_back(predicted_row(CMD_ENQ, 32'h10, 5'd16));
        directed.push_back(checked_row(CMD_ENQ, 32'hAAAA_5555, ST_FULL, 32'h0, 5'd16));
        directed.push_back(checked_row(CMD_ENQ, 32'h0, ST_NULL, 32'h0, 5'd16));
        directed.push_back(checked_row(CMD_DEL, 32'h1F, ST_OK, 32'h0, 5'd15));
        directed.push_back(checked_row(CMD_DEL, 32'h10, ST_OK, 32'h0, 5'd14));
        directed.push_back(checked_row(CMD_DEL, 32'h15, ST_OK, 32'h0, 5'd13));
        directed.push_back(checked_row(CMD_DEL, 32'hDEAD, ST_NOTFOUND, 32'h0, 5'd13));
        directed.push_back(predicted_row(CMD_ENQ, 32'h18, 5'd1));
        directed.push_back(predicted_row(CMD_DEL, 32'h18, 5'd1));
        directed.push_back(predicted_row(CMD_DEQ, 32'h0, 5'd1));

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed[r]) begin
            for (int k = 0; k < directed[r].reps; k++) begin
                item.command = directed[r].command;
                item.value   = directed[r].value + k;
                issue_command(item, directed[r].typed, directed[r].result);
                sender_gap(1'b1);
            end
        end

        random_started <= 1'b1;
        for (int n = 0; n < RANDOM_COMMANDS; n++) begin
            if (n == PAUSE_AT) begin
                in_valid <= 1'b0;
                while (expected_results.size() != 0) @(posedge clk);
            end
            issue_command(random_command(((n / 64) % 2) == 0), 1'b0, '0);
            sender_gap(n >= QUIET_COMMANDS);
        end

        in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Checked %0d results for %0d commands in %0d cycles.",
                 results_checked, commands_sent, cycle_count);
        $display("Outcomes: ok %0d, null %0d, empty %0d, full %0d, not found %0d.",
                 status_seen[ST_OK], status_seen[ST_NULL], status_seen[ST_EMPTY],
                 status_seen[ST_FULL], status_seen[ST_NOTFOUND]);
        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // The first random transactions meet a long hold on the output, so the
    // block backs up into its input; a stretch without stalls follows.
    initial begin : receiver
        int hold_left;
        int quiet_left;
        bit hold_done;
        hold_left  = 0;
        quiet_left = 0;
        hold_done  = 1'b0;
        out_stall <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_left > 0) begin
                out_stall <= 1'b1;
                hold_left--;
            end else if (random_started && !hold_done) begin
                out_stall <= 1'b1;
                hold_left  = HOLD_CYCLES - 1;
                quiet_left = QUIET_CYCLES;
                hold_done  = 1'b1;
            end else if (quiet_left > 0) begin
                out_stall <= 1'b0;
                quiet_left--;
            end else begin
                out_stall <= ($urandom_range(0, 99) < 20);
            end
        end
    end

    always @(negedge clk) begin : result_check
        t_out_item want;
        if (rst_n && o_out_valid && !out_stall) begin
            if (expected_results.size() == 0) begin
                $error("result with no pending command: status %0d, read_value %h, count %0d",
                       o_out_item.status, o_out_item.read_value, o_out_item.count);
                error_count++;
            end else begin
                want = expected_results.pop_front();
                results_checked++;
                if (o_out_item.status !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, o_out_item.status);
                    error_count++;
                end
                if (o_out_item.read_value !== want.read_value) begin
                    $error("read_value: expected %h, actual %h",
                           want.read_value, o_out_item.read_value);
                    error_count++;
                end
                if (o_out_item.count !== want.count) begin
                    $error("count: expected %0d, actual %0d", want.count, o_out_item.count);
                    error_count++;
                end
            end
        end
    end

endmodule

FILE: files.f
design/fqd_pkg.sv
design/fqd_ctrl.sv
design/fqd_datapath.sv
design/fifo_queue_with_delete.sv
tb/fifo_queue_with_delete_tb.sv
